[design/bec_pkg.sv]
// shared types and constants for the box edge collision table
package bec_pkg;

  // table geometry
  localparam int unsigned MaxBodies = 64;
  localparam int unsigned SlotW     = $clog2(MaxBodies);
  localparam int unsigned CountW    = 7;

  // request codes
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // result status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  // register indexes on the configuration port
  localparam logic RegBodyCount = 1'b0;

  // one input item
  typedef struct packed {
    logic               req_type;
    logic [5:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        size_w;
    logic [15:0]        size_h;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic       hit;
    logic [5:0] hit_slot;
    logic       status;
  } out_item_t;

  // one table entry: centre and half extents, Q16.16
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        hx;
    logic [31:0]        hy;
  } box_t;

endpackage

[design/box_edge_collision_first_hit.sv]
// box table with a first-hit edge crossing query, top level
//
// A load item is captured first. The single 16x16 multiplier then forms one
// half extent per step, width first and height second, and the second step
// also writes the table. A last step passes the result to the output register.
// A query whose slot is not below min(body_count, 64) gets a range status
// without a scan. Any other query scans the slots below
// count = min(body_count, 64) and reports the first slot that hits.
// The queried box is read first. Then the table's one read port fetches
// one other box a cycle into a three-stage corner/compare pipeline. The scan
// stops at the first slot that hits, or drains the pipeline when none does.
// The result then sits in an output register, and the next item is taken
// while it waits there. A result that is ready while the output register
// still holds an item the receiver has not taken waits until that item goes.
// The table is not cleared by reset; a query that touches a slot never loaded
// gives undefined fields.
module box_edge_collision_first_hit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bec_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bec_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LDX   = 3'd1;
  localparam logic [2:0] S_LDY   = 3'd2;
  localparam logic [2:0] S_SELF  = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int unsigned SW = bec_pkg::SlotW;
  localparam int unsigned CW = bec_pkg::CountW;

  // half extent: (size * scale) << 7, saturating at all ones
  function automatic logic [31:0] half_ext(input logic [31:0] p);
    logic [31:0] r;
    if (p[31:25] != 7'd0) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = {p[24:0], 7'd0};
    end
    return r;
  endfunction

  // inclusive range compare on 34-bit signed coordinates
  function automatic logic in_rng(input logic signed [33:0] v,
                                  input logic signed [33:0] lo,
                                  input logic signed [33:0] hi);
    return (lo <= v) && (v <= hi);
  endfunction

  logic [2:0]          state_q, state_d;
  bec_pkg::in_item_t   req_q;
  logic [CW-1:0]       body_count_q;
  logic [CW-1:0]       count;
  logic [31:0]         hx_q;
  logic [CW-1:0]       iss_q, iss_d;
  bec_pkg::out_item_t  res_q, res_d;
  bec_pkg::out_item_t  out_q;
  logic                out_valid_q;
  logic                in_acc, cfg_wr;

  // table and its registered read port
  bec_pkg::box_t       tbl_q [bec_pkg::MaxBodies];
  bec_pkg::box_t       rd_q;
  logic [SW-1:0]       rd_addr;

  // shared multiplier
  logic [15:0]         mul_a, mul_b;
  logic [31:0]         prod;

  // self box corners
  logic signed [33:0]  sxl_q, sxh_q, syl_q, syh_q;
  logic                s_hok_q, s_vok_q;

  // pipeline: read, corners, compare
  logic                v1_q, v2_q, v3_q;
  logic [SW-1:0]       t1_q, t2_q, t3_q;
  logic signed [33:0]  cxl_q, cxh_q, cyl_q, cyh_q;
  logic                c_hok_q, c_vok_q;
  logic                hit3_q;
  logic signed [33:0]  rcx, rcy, rhx, rhy;
  logic                role_a, role_b;
  logic                issue, found, scan_done;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;

  // slots in use, capped at the table depth
  assign count = (body_count_q > CW'(bec_pkg::MaxBodies)) ?
                 CW'(bec_pkg::MaxBodies) : body_count_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bec_pkg::RegBodyCount) ?
                  {{(32-CW){1'b0}}, body_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_count_q <= '0;
    end else if (cfg_wr && (paddr[2] == bec_pkg::RegBodyCount)) begin
      body_count_q <= pwdata[CW-1:0];
    end
  end

  // multiplier operands: width in the first load step, height in the second
  assign mul_a = (state_q == S_LDX) ? req_q.size_w  : req_q.size_h;
  assign mul_b = (state_q == S_LDX) ? req_q.scale_x : req_q.scale_y;
  assign prod  = 32'(mul_a) * 32'(mul_b);

  // table write and read
  assign rd_addr = (state_q == S_SELF) ? req_q.slot : iss_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_LDY) begin
      tbl_q[req_q.slot] <= '{cx: req_q.pos_x, cy: req_q.pos_y,
                             hx: hx_q, hy: half_ext(prod)};
    end
    rd_q <= tbl_q[rd_addr];
  end

  // centre and half extents of the box just read, widened to 34 bits
  assign rcx = $signed({{2{rd_q.cx[31]}}, rd_q.cx});
  assign rcy = $signed({{2{rd_q.cy[31]}}, rd_q.cy});
  assign rhx = $signed({2'b00, rd_q.hx});
  assign rhy = $signed({2'b00, rd_q.hy});

  // crossing tests: self vertical edges on candidate horizontal ones, and back
  assign role_a = s_vok_q && c_hok_q &&
                  (in_rng(sxh_q, cxl_q, cxh_q) || in_rng(sxl_q, cxl_q, cxh_q)) &&
                  (in_rng(cyh_q, syl_q, syh_q) || in_rng(cyl_q, syl_q, syh_q));
  assign role_b = c_vok_q && s_hok_q &&
                  (in_rng(cxh_q, sxl_q, sxh_q) || in_rng(cxl_q, sxl_q, sxh_q)) &&
                  (in_rng(syh_q, cyl_q, cyh_q) || in_rng(syl_q, cyl_q, cyh_q));

  // scan control
  assign found     = (state_q == S_SCAN) && v3_q && hit3_q;
  assign issue     = (state_q == S_SCAN) && !found && (iss_q < count);
  assign scan_done = (state_q == S_SCAN) && !found && (iss_q == count) &&
                     !v1_q && !v2_q && !v3_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.req_type == bec_pkg::ReqLoad) begin
            state_d = S_LDX;
          end else if ({1'b0, in_item_i.slot} >= count) begin
            res_d   = '{hit: 1'b0, hit_slot: '0, status: bec_pkg::StatusRange};
            state_d = S_OUT;
          end else begin
            state_d = S_SELF;
          end
        end
      end
      S_LDX: begin
        state_d = S_LDY;
      end
      S_LDY: begin
        res_d   = '{hit: 1'b0, hit_slot: '0, status: bec_pkg::StatusOk};
        state_d = S_OUT;
      end
      S_SELF: begin
        state_d = S_SETUP;
      end
      S_SETUP: begin
        iss_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (found) begin
          res_d   = '{hit: 1'b1, hit_slot: t3_q, status: bec_pkg::StatusOk};
          state_d = S_OUT;
        end else if (scan_done) begin
          res_d   = '{hit: 1'b0, hit_slot: '0, status: bec_pkg::StatusOk};
          state_d = S_OUT;
        end else if (issue) begin
          iss_d = iss_q + CW'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      v1_q    <= issue && (iss_q[SW-1:0] != req_q.slot);
      v2_q    <= v1_q && !found;
      v3_q    <= v2_q && !found;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      req_q <= in_item_i;
    end
    if (state_q == S_LDX) begin
      hx_q <= half_ext(prod);
    end
    // self box corners once its entry is read
    if (state_q == S_SETUP) begin
      sxl_q   <= rcx - rhx;
      sxh_q   <= rcx + rhx;
      syl_q   <= rcy - rhy;
      syh_q   <= rcy + rhy;
      s_hok_q <= (rd_q.hx != 32'd0);
      s_vok_q <= (rd_q.hy != 32'd0);
    end
    // candidate stages
    t1_q    <= iss_q[SW-1:0];
    t2_q    <= t1_q;
    t3_q    <= t2_q;
    cxl_q   <= rcx - rhx;
    cxh_q   <= rcx + rhx;
    cyl_q   <= rcy - rhy;
    cyh_q   <= rcy + rhy;
    c_hok_q <= (rd_q.hx != 32'd0);
    c_vok_q <= (rd_q.hy != 32'd0);
    hit3_q  <= role_a || role_b;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // candidate pipeline is empty outside a scan
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> !(v1_q || v2_q || v3_q))
    else $error("candidate pipeline busy outside scan");

  // scan never issues past the slots in use
  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (iss_q <= count))
    else $error("scan index past slot count");

  // an accepted item keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block free right after accepting an item");

  // a range error never reports a hit
  a_err_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == bec_pkg::StatusRange)) |-> !out_item_o.hit)
    else $error("hit reported with range error");

  // no hit means slot field is zero
  a_nohit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.hit) |-> (out_item_o.hit_slot == '0))
    else $error("hit slot set without a hit");
`endif

endmodule
